>>> rtl/npcs_pkg.sv
// ----------------------------------------------------------------------------
// npcs_pkg: shared types and constants of the nucleotide position count scorer
// Sizes of the count table, fixed-point constants, command codes, the base
// decoder and the request/response structs of the serial divider.
// ----------------------------------------------------------------------------
package npcs_pkg;

    localparam int MAX_WIDTH = 32;
    localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int EW_W      = $clog2(MAX_WIDTH + 1);
    localparam int CFG_W     = 6;
    localparam int WCMP_W    = (EW_W > CFG_W) ? EW_W : CFG_W;
    localparam int CNT_W     = 32;
    localparam int SUM_W     = CNT_W + 2;
    localparam int ROW_W     = 4 * CNT_W;
    localparam int OBS_W     = 16;
    localparam int PROB_W    = 32;
    localparam int DIV_STEPS = 32;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [CNT_W-1:0]  Q_ONE_COUNT = 32'h0000_0100;
    localparam logic [PROB_W-1:0] Q_ONE_PROB  = 32'h8000_0000;
    localparam logic [OBS_W-1:0]  OBS_MAX     = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_SCORE  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic       hit;
        logic [1:0] cls;
    } t_base_class;

    typedef struct packed {
        logic                 start;
        logic [SUM_W-1:0]     rem_init;
        logic [DIV_STEPS-1:0] shift_init;
        logic [SUM_W-1:0]     divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_STEPS-1:0] quot;
    } t_div_rsp;

    function automatic t_base_class base_class(input logic [7:0] ch);
        t_base_class bc;
        bc.hit = 1'b1;
        case (ch)
            8'h41, 8'h61: bc.cls = 2'd0;  // A a
            8'h43, 8'h63: bc.cls = 2'd1;  // C c
            8'h47, 8'h67: bc.cls = 2'd2;  // G g
            8'h54, 8'h74: bc.cls = 2'd3;  // T t
            default: begin
                bc.hit = 1'b0;
                bc.cls = 2'd0;
            end
        endcase
        return bc;
    endfunction

endpackage

>>> rtl/npcs_if.sv
// ----------------------------------------------------------------------------
// npcs_if: channel interfaces of the nucleotide position count scorer
// Base item channel, result channel and configuration write channel, each
// with valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
interface npcs_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [7:0]  base;
    logic [31:0] load_value;
    logic        last;

    modport source (output valid, cmd, base, load_value, last, input ready);
    modport sink   (input valid, cmd, base, load_value, last, output ready);
endinterface

interface npcs_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] observations;
    logic [31:0] probability;
    logic        zero_sum;
    logic        clamped;

    modport source (output valid, observations, probability, zero_sum, clamped,
                    input ready);
    modport sink   (input valid, observations, probability, zero_sum, clamped,
                    output ready);
endinterface

interface npcs_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] motif_width;

    modport source (output valid, motif_width, input ready);
    modport sink   (input valid, motif_width, output ready);
endinterface

>>> rtl/npcs_ram.sv
// ----------------------------------------------------------------------------
// npcs_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module npcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/npcs_div.sv
// ----------------------------------------------------------------------------
// npcs_div: bit-serial restoring divider
// Shifts one dividend bit into the partial remainder per cycle and builds
// the quotient one bit per cycle over a fixed number of steps.
// ----------------------------------------------------------------------------
module npcs_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  npcs_pkg::t_div_req i_req,
    output npcs_pkg::t_div_rsp o_rsp
);

    logic [npcs_pkg::SUM_W-1:0]     r_rem;
    logic [npcs_pkg::DIV_STEPS-1:0] r_shift;
    logic [npcs_pkg::DIV_STEPS-1:0] r_quot;
    logic [npcs_pkg::SUM_W-1:0]     r_divisor;
    logic [npcs_pkg::STEP_W-1:0]    r_step;
    logic                           r_busy;
    logic                           r_done;

    logic [npcs_pkg::SUM_W:0]   trial;
    logic [npcs_pkg::SUM_W+1:0] diff;
    logic                       fits;

    always_comb begin
        trial = {r_rem, r_shift[npcs_pkg::DIV_STEPS-1]};
        diff  = {1'b0, trial} - {2'b00, r_divisor};
        fits  = ~diff[npcs_pkg::SUM_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy    <= 1'b1;
                r_step    <= '0;
                r_rem     <= i_req.rem_init;
                r_shift   <= i_req.shift_init;
                r_divisor <= i_req.divisor;
                r_quot    <= '0;
            end else if (r_busy) begin
                // the partial remainder stays below the divisor, so it fits
                r_rem   <= fits ? diff[npcs_pkg::SUM_W-1:0] : trial[npcs_pkg::SUM_W-1:0];
                r_shift <= {r_shift[npcs_pkg::DIV_STEPS-2:0], 1'b0};
                r_quot  <= {r_quot[npcs_pkg::DIV_STEPS-2:0], fits};
                r_step  <= r_step + 1'b1;
                if (r_step == npcs_pkg::STEP_W'(npcs_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

>>> rtl/nucleotide_position_count_scorer.sv
// ----------------------------------------------------------------------------
// nucleotide_position_count_scorer: position count table with word scoring
// Holds four Q24.8 nucleotide counts per motif column and scores words of
// bases against them as a running Q1.31 product of count / column sum.
// ----------------------------------------------------------------------------
// One base item is taken at a time. Load, add, remove and skipped characters
// go through the column row read, the registered read data, the write back
// (none for a skipped character) and the column advance before the earliest
// next transfer. A score item, after the row read and a registered column
// sum, takes the ratio count * 2^31 / sum from the bit-serial divider, one
// quotient bit per cycle, and one 32x32 multiply folds it into the running
// product; a score on a column with zero sum skips the divider. For the item
// marked last the same divider then forms bases / motif width, and the result
// is loaded into the output register once it is free; the register holds it
// until it is taken while new items are already accepted. The count table is
// a RAM of one 128-bit row per column; a valid bit per row, cleared by reset,
// makes a never written row read as all zero, so no clearing pass is needed.
// The motif width is written over the configuration channel; the user must
// write it only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module nucleotide_position_count_scorer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    npcs_in_if.sink     i_in,
    npcs_out_if.source  o_out,
    npcs_cfg_if.sink    i_cfg
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_DIVGO,
        S_DIV,
        S_MUL,
        S_FINISH,
        S_OBS
    } t_state;

    t_state r_state;

    // latched item
    logic [1:0]                  r_cmd;
    logic                        r_hit;
    logic [1:0]                  r_cls;
    logic [npcs_pkg::CNT_W-1:0]  r_load;
    logic                        r_last;

    // configuration and word state
    logic [npcs_pkg::CFG_W-1:0]     r_mw;
    logic [npcs_pkg::COL_W-1:0]     r_col;
    logic [npcs_pkg::OBS_W-1:0]     r_bases;
    logic [npcs_pkg::PROB_W-1:0]    r_prod;
    logic                           r_zero;
    logic                           r_clamp;
    logic [npcs_pkg::MAX_WIDTH-1:0] r_valid;

    // score operands
    logic [npcs_pkg::SUM_W-1:0] r_sum;
    logic [npcs_pkg::CNT_W-1:0] r_sel;

    // output register
    logic                         r_out_valid;
    logic [npcs_pkg::OBS_W-1:0]   r_out_obs;
    logic [npcs_pkg::PROB_W-1:0]  r_out_prob;
    logic                         r_out_zero;
    logic                         r_out_clamp;
    logic                         r_emit;

    logic                        in_xfer;
    logic                        out_load;
    npcs_pkg::t_base_class       bc;
    logic [npcs_pkg::EW_W-1:0]   eff_w;
    logic [npcs_pkg::WCMP_W-1:0] mw_ext;
    logic [npcs_pkg::WCMP_W-1:0] col_inc;
    logic [npcs_pkg::COL_W-1:0]  n_col;
    logic [npcs_pkg::OBS_W-1:0]  n_bases;

    logic [npcs_pkg::ROW_W-1:0]  ram_rdata;
    logic [npcs_pkg::ROW_W-1:0]  row;
    logic [npcs_pkg::ROW_W-1:0]  n_row;
    logic [npcs_pkg::CNT_W-1:0]  cur_cnt;
    logic [npcs_pkg::CNT_W-1:0]  n_cell;
    logic [npcs_pkg::CNT_W:0]    cell_inc;
    logic                        n_clamp_hit;
    logic [npcs_pkg::SUM_W-1:0]  row_sum;
    logic                        ram_we;
    logic [63:0]                 mul;

    npcs_pkg::t_div_req div_req;
    npcs_pkg::t_div_rsp div_rsp;

    assign in_xfer     = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign bc          = npcs_pkg::base_class(i_in.base);

    // load the output register once the word quotient is there and it is free
    assign out_load = (r_state == S_OBS) && (div_rsp.done || r_emit) &&
                      (!r_out_valid || o_out.ready);

    // clamp the configured width into 1..MAX_WIDTH
    always_comb begin
        mw_ext = npcs_pkg::WCMP_W'(r_mw);
        if (r_mw == '0) begin
            eff_w = npcs_pkg::EW_W'(1);
        end else if (mw_ext > npcs_pkg::WCMP_W'(npcs_pkg::MAX_WIDTH)) begin
            eff_w = npcs_pkg::EW_W'(npcs_pkg::MAX_WIDTH);
        end else begin
            eff_w = npcs_pkg::EW_W'(r_mw);
        end
        col_inc = npcs_pkg::WCMP_W'(r_col) + 1'b1;
        n_col   = (col_inc >= npcs_pkg::WCMP_W'(eff_w)) ? '0 : npcs_pkg::COL_W'(col_inc);
        n_bases = (r_bases == npcs_pkg::OBS_MAX) ? r_bases : r_bases + 1'b1;
    end

    // column row: an unwritten row reads as zero counts
    always_comb begin
        row      = r_valid[r_col] ? ram_rdata : '0;
        cur_cnt  = row[r_cls*npcs_pkg::CNT_W +: npcs_pkg::CNT_W];
        cell_inc = {1'b0, cur_cnt} + {1'b0, npcs_pkg::Q_ONE_COUNT};
        n_clamp_hit = 1'b0;
        case (npcs_pkg::t_cmd'(r_cmd))
            npcs_pkg::CMD_LOAD: n_cell = r_load;
            npcs_pkg::CMD_ADD:  n_cell = cell_inc[npcs_pkg::CNT_W] ? '1 :
                                         cell_inc[npcs_pkg::CNT_W-1:0];
            npcs_pkg::CMD_REMOVE: begin
                if (cur_cnt < npcs_pkg::Q_ONE_COUNT) begin
                    n_cell      = '0;
                    n_clamp_hit = 1'b1;
                end else begin
                    n_cell = cur_cnt - npcs_pkg::Q_ONE_COUNT;
                end
            end
            default: n_cell = cur_cnt;
        endcase
        n_row = row;
        n_row[r_cls*npcs_pkg::CNT_W +: npcs_pkg::CNT_W] = n_cell;
        row_sum = npcs_pkg::SUM_W'(row[0 +: npcs_pkg::CNT_W])
                + npcs_pkg::SUM_W'(row[npcs_pkg::CNT_W +: npcs_pkg::CNT_W])
                + npcs_pkg::SUM_W'(row[2*npcs_pkg::CNT_W +: npcs_pkg::CNT_W])
                + npcs_pkg::SUM_W'(row[3*npcs_pkg::CNT_W +: npcs_pkg::CNT_W]);
        ram_we = (r_state == S_EXEC) && r_hit &&
                 (npcs_pkg::t_cmd'(r_cmd) != npcs_pkg::CMD_SCORE);
    end

    // divider requests: ratio count * 2^31 / sum, or bases / width at word end
    always_comb begin
        div_req = '0;
        if (r_state == S_DIVGO) begin
            div_req.start      = (r_sum != '0);
            div_req.rem_init   = npcs_pkg::SUM_W'(r_sel[npcs_pkg::CNT_W-1:1]);
            div_req.shift_init = {r_sel[0], {(npcs_pkg::DIV_STEPS-1){1'b0}}};
            div_req.divisor    = r_sum;
        end else if (r_state == S_FINISH) begin
            div_req.start      = r_last;
            div_req.rem_init   = '0;
            div_req.shift_init = npcs_pkg::DIV_STEPS'(n_bases);
            div_req.divisor    = npcs_pkg::SUM_W'(eff_w);
        end
    end

    assign mul = {32'd0, r_prod} * {32'd0, div_rsp.quot};

    npcs_ram #(
        .WIDTH (npcs_pkg::ROW_W),
        .DEPTH (npcs_pkg::MAX_WIDTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_col),
        .i_wdata (n_row),
        .i_re    (in_xfer),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    npcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mw        <= npcs_pkg::CFG_W'(1);
            r_col       <= '0;
            r_bases     <= '0;
            r_prod      <= npcs_pkg::Q_ONE_PROB;
            r_zero      <= 1'b0;
            r_clamp     <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_emit      <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_mw <= i_cfg.motif_width;
            end
            // drop the result once the sink takes it, unless a new one replaces it
            if (r_out_valid && o_out.ready && !out_load) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_cmd   <= i_in.cmd;
                        r_hit   <= bc.hit;
                        r_cls   <= bc.cls;
                        r_load  <= i_in.load_value;
                        r_last  <= i_in.last;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (!r_hit) begin
                        r_state <= S_FINISH;
                    end else if (npcs_pkg::t_cmd'(r_cmd) == npcs_pkg::CMD_SCORE) begin
                        r_sum   <= row_sum;
                        r_sel   <= cur_cnt;
                        r_state <= S_DIVGO;
                    end else begin
                        r_valid[r_col] <= 1'b1;
                        if (n_clamp_hit) begin
                            r_clamp <= 1'b1;
                        end
                        r_state <= S_FINISH;
                    end
                end
                S_DIVGO: begin
                    if (r_sum == '0) begin
                        r_zero  <= 1'b1;
                        r_state <= S_FINISH;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= mul[62:31];
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    r_bases <= n_bases;
                    r_col   <= n_col;
                    r_emit  <= 1'b0;
                    r_state <= r_last ? S_OBS : S_IDLE;
                end
                S_OBS: begin
                    // hold the quotient until the output register is free
                    if (out_load) begin
                        r_out_valid <= 1'b1;
                        r_out_obs   <= div_rsp.quot[npcs_pkg::OBS_W-1:0];
                        r_out_prob  <= r_zero ? '0 : r_prod;
                        r_out_zero  <= r_zero;
                        r_out_clamp <= r_clamp;
                        r_col       <= '0;
                        r_bases     <= '0;
                        r_prod      <= npcs_pkg::Q_ONE_PROB;
                        r_zero      <= 1'b0;
                        r_clamp     <= 1'b0;
                        r_emit      <= 1'b0;
                        r_state     <= S_IDLE;
                    end else if (div_rsp.done) begin
                        r_emit <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.observations = r_out_obs;
    assign o_out.probability  = r_out_prob;
    assign o_out.zero_sum     = r_out_zero;
    assign o_out.clamped      = r_out_clamp;

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the nucleotide position count scorer
// Streams words of base items with random gaps, takes word results with
// random stalls and compares every field against a model of the count
// table, the running Q1.31 product and the word counters. The motif width
// is rewritten between phases while the block is idle, and once mid-word.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int WIND_DOWN   = 100;     // score plus end of word, with margin
    localparam int PHASE_ITEMS = 140;
    localparam logic [63:0] NUC_CHARS = "ACGTacgt";

    typedef enum logic [1:0] {NUC_A, NUC_C, NUC_G, NUC_T} t_nuc;

    typedef struct packed {
        npcs_pkg::t_cmd cmd;
        logic [7:0]     ch;
        logic [31:0]    load_value;
        logic           last_base;
    } t_base_item;

    typedef struct packed {
        logic [15:0] observations;
        logic [31:0] probability;
        logic        zero_sum;
        logic        clamped;
    } t_word_score;

    logic i_clk = 1'b0;
    logic i_rst_n;

    npcs_in_if  in_ch ();
    npcs_out_if out_ch ();
    npcs_cfg_if cfg_ch ();

    nucleotide_position_count_scorer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Model of the block: count table, width register and word state
    logic [31:0]                nuc_counts [npcs_pkg::MAX_WIDTH*4];
    logic [5:0]                 width_setting;
    logic [npcs_pkg::COL_W-1:0] column_pos;
    logic [15:0]                word_bases;
    logic [31:0]                word_product;
    logic                       word_zero_sum;
    logic                       word_clamped;

    t_base_item  base_feed [$];
    t_word_score word_scores [$];

    int  cycle_count    = 0;
    int  mismatch_count = 0;
    int  items_taken    = 0;
    int  score_items    = 0;
    int  words_checked  = 0;
    int  widths_written = 0;
    int  gap_pct        = 0;
    int  stall_pct      = 0;
    int  send_gap       = 0;
    int  recv_stall     = 0;
    bit  calm           = 1'b0;
    bit  base_taken     = 1'b0;

    function automatic int width_span(input logic [5:0] setting);
        if (setting == '0)
            return 1;
        if (int'(setting) > npcs_pkg::MAX_WIDTH)
            return npcs_pkg::MAX_WIDTH;
        return int'(setting);
    endfunction

    // Apply one accepted base to the model; queue a word score on the last.
    task automatic track_base(input t_base_item it);
        int          span;
        int          row;
        int          slot;
        logic        hit;
        t_nuc        nuc;
        logic [33:0] col_sum;
        logic [63:0] ratio;
        logic [63:0] prod;
        t_word_score res;
        span = width_span(width_setting);
        hit  = 1'b1;
        nuc  = NUC_A;
        case (it.ch)
            "A", "a": nuc = NUC_A;
            "C", "c": nuc = NUC_C;
            "G", "g": nuc = NUC_G;
            "T", "t": nuc = NUC_T;
            default:  hit = 1'b0;
        endcase
        row  = int'(column_pos) * 4;
        slot = row + int'(nuc);
        if (hit) begin
            case (it.cmd)
                npcs_pkg::CMD_LOAD: nuc_counts[slot] = it.load_value;
                npcs_pkg::CMD_ADD: begin
                    if (nuc_counts[slot] > 32'hFFFF_FFFF - npcs_pkg::Q_ONE_COUNT)
                        nuc_counts[slot] = 32'hFFFF_FFFF;
                    else
                        nuc_counts[slot] = nuc_counts[slot] + npcs_pkg::Q_ONE_COUNT;
                end
                npcs_pkg::CMD_REMOVE: begin
                    // clamp at zero and flag the word
                    if (nuc_counts[slot] < npcs_pkg::Q_ONE_COUNT) begin
                        nuc_counts[slot] = '0;
                        word_clamped = 1'b1;
                    end else begin
                        nuc_counts[slot] = nuc_counts[slot] - npcs_pkg::Q_ONE_COUNT;
                    end
                end
                npcs_pkg::CMD_SCORE: begin
                    col_sum = {2'b00, nuc_counts[row]} + {2'b00, nuc_counts[row+1]}
                            + {2'b00, nuc_counts[row+2]} + {2'b00, nuc_counts[row+3]};
                    if (col_sum == '0) begin
                        word_zero_sum = 1'b1;
                    end else begin
                        ratio = {1'b0, nuc_counts[slot], 31'b0} / {30'b0, col_sum};
                        prod  = {32'b0, word_product} * ratio;
                        word_product = prod[62:31];
                    end
                end
            endcase
        end
        if (word_bases != npcs_pkg::OBS_MAX)
            word_bases = word_bases + 1'b1;
        column_pos = (int'(column_pos) + 1 >= span) ? '0 : column_pos + 1'b1;
        if (it.last_base) begin
            res.observations = 16'(int'(word_bases) / span);
            res.probability  = word_zero_sum ? '0 : word_product;
            res.zero_sum     = word_zero_sum;
            res.clamped      = word_clamped;
            word_scores.push_back(res);
            column_pos    = '0;
            word_bases    = '0;
            word_product  = npcs_pkg::Q_ONE_PROB;
            word_zero_sum = 1'b0;
            word_clamped  = 1'b0;
        end
    endtask

    // Sample both channels at the rising edge: check results, then model inputs.
    always @(posedge i_clk) begin : score_check
        t_word_score want;
        t_base_item  seen;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, word_scores.size());
            $display("[nucleotide_position_count_scorer] ERROR");
            $finish;
        end else if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                words_checked++;
                if (word_scores.size() == 0) begin
                    $display("%0t: unexpected result obs=%0d prob=%h zs=%b cl=%b", $time,
                             out_ch.observations, out_ch.probability,
                             out_ch.zero_sum, out_ch.clamped);
                    mismatch_count++;
                end else begin
                    want = word_scores.pop_front();
                    if (out_ch.observations !== want.observations) begin
                        $display("%0t: observations expected %0d, actual %0d", $time,
                                 want.observations, out_ch.observations);
                        mismatch_count++;
                    end
                    if (out_ch.probability !== want.probability) begin
                        $display("%0t: probability expected %h, actual %h", $time,
                                 want.probability, out_ch.probability);
                        mismatch_count++;
                    end
                    if (out_ch.zero_sum !== want.zero_sum) begin
                        $display("%0t: zero_sum expected %b, actual %b", $time,
                                 want.zero_sum, out_ch.zero_sum);
                        mismatch_count++;
                    end
                    if (out_ch.clamped !== want.clamped) begin
                        $display("%0t: clamped expected %b, actual %b", $time,
                                 want.clamped, out_ch.clamped);
                        mismatch_count++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                seen.cmd        = npcs_pkg::t_cmd'(in_ch.cmd);
                seen.ch         = in_ch.base;
                seen.load_value = in_ch.load_value;
                seen.last_base  = in_ch.last;
                if (seen.cmd == npcs_pkg::CMD_SCORE)
                    score_items++;
                items_taken++;
                track_base(seen);
                base_taken = 1'b1;
            end
        end
    end

    // Sender: hold an item until its transfer, then advance or idle a burst.
    always @(negedge i_clk) begin : base_driver
        t_base_item it;
        if (i_rst_n && (!in_ch.valid || base_taken)) begin
            base_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                in_ch.valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < gap_pct) begin
                send_gap = $urandom_range(0, 14);
                in_ch.valid <= 1'b0;
            end else if (base_feed.size() != 0) begin
                it = base_feed.pop_front();
                in_ch.valid      <= 1'b1;
                in_ch.cmd        <= it.cmd;
                in_ch.base       <= it.ch;
                in_ch.load_value <= it.load_value;
                in_ch.last       <= it.last_base;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: hold ready low in random bursts, except in the calm last part.
    always @(negedge i_clk) begin : result_sink
        if (recv_stall > 0) begin
            recv_stall--;
            out_ch.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
            recv_stall = $urandom_range(0, 14);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    task automatic push_base(input npcs_pkg::t_cmd cmd, input logic [7:0] ch,
                             input logic [31:0] value, input logic last_base);
        t_base_item it;
        it.cmd        = cmd;
        it.ch         = ch;
        it.load_value = value;
        it.last_base  = last_base;
        base_feed.push_back(it);
    endtask

    // Drain everything sent, then let the block finish its last item.
    task automatic wait_for_idle();
        while (base_feed.size() != 0 || in_ch.valid || word_scores.size() != 0)
            @(posedge i_clk);
        repeat (WIND_DOWN) @(posedge i_clk);
    endtask

    task automatic write_width(input logic [5:0] setting);
        @(negedge i_clk);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.motif_width <= setting;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        width_setting = setting;
        widths_written++;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic t_base_item random_base(input bit tidy);
        t_base_item it;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            it.cmd = npcs_pkg::CMD_SCORE;
        else if (pick < 65)
            it.cmd = npcs_pkg::CMD_ADD;
        else if (pick < 80)
            it.cmd = npcs_pkg::CMD_LOAD;
        else
            it.cmd = npcs_pkg::CMD_REMOVE;
        pick = $urandom_range(0, 7);
        if (!tidy || $urandom_range(0, 9) == 0)
            it.ch = 8'($urandom_range(0, 255));
        else
            it.ch = NUC_CHARS[8*pick +: 8];
        // mostly small pseudo-counts so adds and removes matter, some full range
        case ($urandom_range(0, 3))
            0:       it.load_value = $urandom();
            1:       it.load_value = 32'($urandom_range(1, 8)) << 8;
            2:       it.load_value = 32'($urandom_range(0, 'h3FF));
            default: it.load_value = '0;
        endcase
        it.last_base = 1'b0;
        return it;
    endfunction

    // One phase: new width, then words until the phase quota is queued.
    // Most words are whole observations; the rest have odd lengths and noise.
    task automatic run_phase(input logic [5:0] setting, input int idle_pct);
        int         span;
        int         queued;
        int         length;
        bit         tidy;
        t_base_item it;
        wait_for_idle();
        write_width(setting);
        gap_pct   = idle_pct;
        stall_pct = idle_pct;
        span      = width_span(setting);
        queued    = 0;
        while (queued < PHASE_ITEMS) begin
            tidy   = ($urandom_range(0, 4) != 0);
            length = tidy ? span * $urandom_range(1, 3) : $urandom_range(1, 2 * span + 3);
            for (int k = 0; k < length; k++) begin
                it = random_base(tidy);
                it.last_base = (k == length - 1);
                base_feed.push_back(it);
            end
            queued += length;
        end
    endtask

    initial begin : stimulus
        i_rst_n              = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.cmd            = npcs_pkg::CMD_LOAD;
        in_ch.base           = '0;
        in_ch.load_value     = '0;
        in_ch.last           = 1'b0;
        out_ch.ready         = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.motif_width   = '0;
        foreach (nuc_counts[k])
            nuc_counts[k] = '0;
        width_setting = 6'd1;
        column_pos    = '0;
        word_bases    = '0;
        word_product  = npcs_pkg::Q_ONE_PROB;
        word_zero_sum = 1'b0;
        word_clamped  = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words at the reset width of one column
        gap_pct   = 30;
        stall_pct = 30;
        push_base(npcs_pkg::CMD_SCORE,  "A", '0, 1'b1);   // empty column: zero sum
        push_base(npcs_pkg::CMD_LOAD,   "A", 32'hFFFF_FFFF, 1'b0);
        push_base(npcs_pkg::CMD_LOAD,   "c", npcs_pkg::Q_ONE_COUNT, 1'b0);
        push_base(npcs_pkg::CMD_LOAD,   "G", '0, 1'b0);
        push_base(npcs_pkg::CMD_LOAD,   "t", 32'h80, 1'b0);
        push_base(npcs_pkg::CMD_ADD,    "a", '0, 1'b0);   // add saturates
        push_base(npcs_pkg::CMD_REMOVE, "g", '0, 1'b0);   // remove from zero clamps
        push_base(npcs_pkg::CMD_REMOVE, "T", '0, 1'b0);   // below one count clamps
        push_base(npcs_pkg::CMD_SCORE,  "x", '0, 1'b0);   // skipped character
        push_base(npcs_pkg::CMD_SCORE,  "a", '0, 1'b0);   // column sum above 32 bits
        push_base(npcs_pkg::CMD_SCORE,  "C", '0, 1'b0);
        push_base(npcs_pkg::CMD_SCORE,  "g", '0, 1'b0);   // zero count zeroes product
        push_base(npcs_pkg::CMD_LOAD,   "N", 32'hFFFF_FFFF, 1'b1);
        push_base(npcs_pkg::CMD_ADD,    8'hFF, '0, 1'b1); // no score: reports one
        push_base(npcs_pkg::CMD_SCORE,  8'h00, '0, 1'b1);
        push_base(npcs_pkg::CMD_SCORE,  "A", '0, 1'b1);

        // Width zero acts as one column
        wait_for_idle();
        write_width(6'd0);
        push_base(npcs_pkg::CMD_SCORE, "a", '0, 1'b0);
        push_base(npcs_pkg::CMD_ADD,   "c", '0, 1'b0);
        push_base(npcs_pkg::CMD_SCORE, "c", '0, 1'b1);

        // All ones acts as the largest width
        wait_for_idle();
        write_width(6'd63);
        push_base(npcs_pkg::CMD_LOAD,  "G", 32'h300, 1'b0);
        push_base(npcs_pkg::CMD_SCORE, "t", '0, 1'b0);
        push_base(npcs_pkg::CMD_ADD,   "A", '0, 1'b1);

        // Width shrinks mid-word: the column past the new width is used, then wraps
        wait_for_idle();
        write_width(6'd4);
        push_base(npcs_pkg::CMD_ADD, "A", '0, 1'b0);
        push_base(npcs_pkg::CMD_ADD, "C", '0, 1'b0);
        push_base(npcs_pkg::CMD_ADD, "G", '0, 1'b0);
        wait_for_idle();
        write_width(6'd2);
        push_base(npcs_pkg::CMD_SCORE, "T", '0, 1'b0);
        push_base(npcs_pkg::CMD_SCORE, "a", '0, 1'b1);

        // Random phases over several widths, with and without idling
        run_phase(6'd1, 25);
        run_phase(6'd3, 0);
        run_phase(6'd32, 25);
        run_phase(6'd2, 40);
        run_phase(6'd63, 0);
        run_phase(6'($urandom_range(4, 8)), 25);
        run_phase(6'd0, 25);
        run_phase(6'($urandom_range(9, 31)), 15);
        run_phase(6'd5, 25);

        // Last part without idling
        wait_for_idle();
        calm = 1'b1;
        run_phase(6'($urandom_range(1, 6)), 0);

        wait_for_idle();
        $display("run covered %0d base transfers, %0d of them score commands, %0d words",
                 items_taken, score_items, words_checked);
        $display("motif width written %0d times, extremes and a mid-word change included",
                 widths_written);
        if (mismatch_count == 0)
            $display("[nucleotide_position_count_scorer] OK");
        else
            $display("[nucleotide_position_count_scorer] ERROR");
        $finish;
    end

endmodule

>>> nucleotide_position_count_scorer.f
rtl/npcs_pkg.sv
rtl/npcs_if.sv
rtl/npcs_ram.sv
rtl/npcs_div.sv
rtl/nucleotide_position_count_scorer.sv
tb/sv/testbench.sv
